// ===== src/lps_pkg.sv =====
// lps_pkg: shared types and constants for the led pattern sequencer
// no dependencies; used by lps_engine, the top level and the bench
package lps_pkg;

    // item operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // pattern command codes (codes 6 and 7 behave as none)
    localparam logic [2:0] CMD_NONE          = 3'd0;
    localparam logic [2:0] CMD_BLINK_ONCE    = 3'd1;
    localparam logic [2:0] CMD_BLINK_TWICE   = 3'd2;
    localparam logic [2:0] CMD_FADE_IN       = 3'd3;
    localparam logic [2:0] CMD_FADE_OUT      = 3'd4;
    localparam logic [2:0] CMD_BLINK_FOREVER = 3'd5;

    // fade ramp: 128-tick pwm period, duty point starts at 127
    localparam logic [31:0] FADE_PERIOD = 32'd128;
    localparam logic [6:0]  FADE_TOP    = 7'd127;

    // blink phase length after reset
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd1400;

    // input item payload
    typedef struct packed {
        logic       op;
        logic [2:0] command;
    } in_item_t;

    // result item payload
    typedef struct packed {
        logic       led_lit;
        logic [2:0] active_command;
        logic       finished;
    } out_item_t;

endpackage

// ===== src/lps_in_if.sv =====
// lps_in_if: valid/ready channel carrying tick and command-write items
// no dependencies
interface lps_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [2:0] command;

    modport source (output valid, output op, output command, input ready);
    modport sink   (input valid, input op, input command, output ready);
endinterface

// ===== src/lps_out_if.sv =====
// lps_out_if: valid/ready channel carrying led status items
// no dependencies
interface lps_out_if;
    logic       valid;
    logic       ready;
    logic       led_lit;
    logic [2:0] active_command;
    logic       finished;

    modport source (output valid, output led_lit, output active_command,
                    output finished, input ready);
    modport sink   (input valid, input led_lit, input active_command,
                    input finished, output ready);
endinterface

// ===== src/led_pattern_sequencer_top.sv =====
// led_pattern_sequencer_top: input register, pattern engine, result register
// depends on lps_pkg, lps_in_if, lps_out_if and lps_engine
//
// Command-driven LED pattern engine. Each input item is one tick or a command
// write; each gives exactly one status item (led_lit, active_command and a
// finished flag for the tick that ends a pattern). An item is taken in every
// clock cycle while the status side keeps taking results: it waits in the input
// register, the engine updates the pattern state as it moves on, and it then
// sits in the result register, so the throughput is one item per cycle under
// that condition. phase_ticks may be written only while no item is in flight.
module led_pattern_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    lps_in_if.sink      tick_cmd,
    lps_out_if.source   status,
    input  logic        phase_ticks_we,
    input  logic [15:0] phase_ticks_wdata
);
    import lps_pkg::*;

    logic [15:0] phase_ticks_reg;
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   result;
    logic        stage_go;
    logic        advance;

    // pipeline control: the input stage moves when the result register is free
    assign stage_go       = !out_valid_reg || status.ready;
    assign advance        = in_valid_reg && stage_go;
    assign tick_cmd.ready = !in_valid_reg || stage_go;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (phase_ticks_we)
        begin
            phase_ticks_reg <= phase_ticks_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (tick_cmd.ready)
        begin
            in_valid_reg <= tick_cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_cmd.valid && tick_cmd.ready)
        begin
            in_item_reg.op      <= tick_cmd.op;
            in_item_reg.command <= tick_cmd.command;
        end
    end

    // pattern engine
    lps_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .phase_ticks (phase_ticks_reg),
        .item        (in_item_reg),
        .advance     (advance),
        .result      (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_go)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign status.valid          = out_valid_reg;
    assign status.led_lit        = out_item_reg.led_lit;
    assign status.active_command = out_item_reg.active_command;
    assign status.finished       = out_item_reg.finished;

endmodule

// ===== src/lps_engine.sv =====
// lps_engine: pattern state registers and the per-item next-state logic
// depends on lps_pkg
module lps_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        phase_ticks,
    input  lps_pkg::in_item_t  item,
    input  logic               advance,
    output lps_pkg::out_item_t result
);
    import lps_pkg::*;

    logic [2:0]  cmd_reg, cmd_next;
    logic [6:0]  phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic        led_reg, led_next;
    logic        done;
    logic        count_inc;
    logic        phase_done;
    logic        lit_end;

    assign phase_done = count_reg >= {16'd0, phase_ticks};
    assign lit_end    = (cmd_reg == CMD_FADE_IN);

    // next state for one item
    always_comb
    begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        led_next   = led_reg;
        done       = 1'b0;
        count_inc  = 1'b1;
        if (item.op == OP_WRITE)
        begin
            cmd_next  = item.command;
            count_inc = 1'b0;
        end
        else
        begin
            case (cmd_reg) inside
                CMD_BLINK_ONCE:
                begin
                    if (phase_reg == 7'd0)
                    begin
                        led_next   = 1'b1;
                        phase_next = 7'd1;
                        count_next = 32'd0;
                    end
                    else if (phase_done)
                    begin
                        led_next   = 1'b0;
                        phase_next = 7'd0;
                        cmd_next   = CMD_NONE;
                        done       = 1'b1;
                    end
                end
                CMD_BLINK_TWICE:
                begin
                    if (phase_reg == 7'd0)
                    begin
                        led_next   = 1'b1;
                        phase_next = 7'd1;
                        count_next = 32'd0;
                    end
                    else if (phase_reg <= 7'd3 && phase_done)
                    begin
                        if (phase_reg == 7'd3)
                        begin
                            led_next   = 1'b0;
                            phase_next = 7'd0;
                            cmd_next   = CMD_NONE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            led_next   = (phase_reg != 7'd1);
                            phase_next = phase_reg + 7'd1;
                            count_next = 32'd0;
                        end
                    end
                end
                CMD_FADE_IN, CMD_FADE_OUT:
                begin
                    if (phase_reg == 7'd0)
                    begin
                        led_next   = ~lit_end;
                        phase_next = FADE_TOP;
                        count_next = 32'd0;
                    end
                    else if (phase_reg == 7'd1)
                    begin
                        led_next   = lit_end;
                        phase_next = 7'd0;
                        cmd_next   = CMD_NONE;
                        done       = 1'b1;
                    end
                    else if (count_reg == FADE_PERIOD)
                    begin
                        led_next   = ~lit_end;
                        count_next = 32'd0;
                        phase_next = phase_reg - 7'd1;
                    end
                    else if (count_reg == {25'd0, phase_reg})
                    begin
                        led_next = lit_end;
                    end
                end
                CMD_BLINK_FOREVER:
                begin
                    if (phase_reg == 7'd0)
                    begin
                        led_next   = 1'b1;
                        phase_next = 7'd1;
                        count_next = 32'd0;
                    end
                    else if (phase_reg == 7'd1)
                    begin
                        if (phase_done)
                        begin
                            led_next   = 1'b0;
                            phase_next = 7'd2;
                            count_next = 32'd0;
                        end
                    end
                    else if (phase_reg == 7'd2)
                    begin
                        if (phase_done)
                        begin
                            phase_next = 7'd0;
                        end
                    end
                end
                default:
                begin
                    count_inc = 1'b0;
                end
            endcase
            if (count_inc)
            begin
                count_next = count_next + 32'd1;
            end
        end
    end

    // result fields reflect the state after this item
    assign result.led_lit        = led_next;
    assign result.active_command = cmd_next;
    assign result.finished       = done;

    // state update once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= CMD_NONE;
            phase_reg <= 7'd0;
            count_reg <= 32'd0;
            led_reg   <= 1'b0;
        end
        else if (advance)
        begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            led_reg   <= led_next;
        end
    end

    // a command write never completes a pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.op == OP_WRITE |-> !result.finished)
        else $error("finished raised on a command write");

    // a completed pattern leaves no command and phase zero
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && result.finished |=> cmd_reg == CMD_NONE && phase_reg == 7'd0)
        else $error("pattern state not cleared after finish");

    // a command write keeps phase and counter
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.op == OP_WRITE
        |=> count_reg == $past(count_reg) && phase_reg == $past(phase_reg))
        else $error("command write disturbed phase or counter");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for led_pattern_sequencer_top
// depends on lps_pkg, lps_in_if, lps_out_if and the top level RTL
module tb;
    import lps_pkg::*;

    localparam int STALL_LIMIT   = 400;
    localparam int SETTLE_CYCLES = 6;
    localparam int FADE_TICKS    = 140;
    localparam int PRINT_CAP     = 40;

    logic        clk;
    logic        rst_n;
    logic        phase_ticks_we;
    logic [15:0] phase_ticks_wdata;

    lps_in_if  tick_cmd ();
    lps_out_if status ();

    led_pattern_sequencer_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .tick_cmd         (tick_cmd),
        .status           (status),
        .phase_ticks_we   (phase_ticks_we),
        .phase_ticks_wdata(phase_ticks_wdata)
    );

    // predicted pattern state and blink length
    logic [15:0] blink_len;
    logic [2:0]  pat_cmd;
    logic [6:0]  pat_step;
    logic [31:0] pat_count;
    logic        pat_lit;

    in_item_t    pending_items[$];
    out_item_t   status_due[$];
    in_item_t    taken_item;
    in_item_t    next_item;
    out_item_t   want;
    int          items_queued = 0;
    int          error_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          idle_cycles = 0;
    logic [15:0] stall_pattern;
    logic [3:0]  stall_phase;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // advance the predicted pattern by one item and return its status
    function automatic out_item_t advance_pattern(in_item_t item);
        out_item_t  res;
        logic       done;
        logic       lit_end;
        logic [2:0] entry_cmd;
        done      = 1'b0;
        entry_cmd = pat_cmd;
        lit_end   = (entry_cmd == CMD_FADE_IN);
        if (item.op == OP_WRITE)
        begin
            pat_cmd = item.command;
        end
        else
        begin
            case (entry_cmd)
                CMD_BLINK_ONCE:
                begin
                    if (pat_step == 7'd0)
                    begin
                        pat_lit   = 1'b1;
                        pat_step  = 7'd1;
                        pat_count = '0;
                    end
                    else if (pat_count >= blink_len)
                    begin
                        pat_lit  = 1'b0;
                        pat_step = 7'd0;
                        pat_cmd  = CMD_NONE;
                        done     = 1'b1;
                    end
                end
                CMD_BLINK_TWICE:
                begin
                    if (pat_step == 7'd0)
                    begin
                        pat_lit   = 1'b1;
                        pat_step  = 7'd1;
                        pat_count = '0;
                    end
                    else if (pat_step <= 7'd3 && pat_count >= blink_len)
                    begin
                        if (pat_step == 7'd3)
                        begin
                            pat_lit  = 1'b0;
                            pat_step = 7'd0;
                            pat_cmd  = CMD_NONE;
                            done     = 1'b1;
                        end
                        else
                        begin
                            pat_lit   = (pat_step != 7'd1);
                            pat_step  = pat_step + 7'd1;
                            pat_count = '0;
                        end
                    end
                end
                CMD_FADE_IN, CMD_FADE_OUT:
                begin
                    if (pat_step == 7'd0)
                    begin
                        pat_lit   = ~lit_end;
                        pat_step  = FADE_TOP;
                        pat_count = '0;
                    end
                    else if (pat_step == 7'd1)
                    begin
                        pat_lit  = lit_end;
                        pat_step = 7'd0;
                        pat_cmd  = CMD_NONE;
                        done     = 1'b1;
                    end
                    else if (pat_count == FADE_PERIOD)
                    begin
                        pat_lit   = ~lit_end;
                        pat_count = '0;
                        pat_step  = pat_step - 7'd1;
                    end
                    else if (pat_count == {25'd0, pat_step})
                    begin
                        pat_lit = lit_end;
                    end
                end
                CMD_BLINK_FOREVER:
                begin
                    if (pat_step == 7'd0)
                    begin
                        pat_lit   = 1'b1;
                        pat_step  = 7'd1;
                        pat_count = '0;
                    end
                    else if (pat_step == 7'd1)
                    begin
                        if (pat_count >= blink_len)
                        begin
                            pat_lit   = 1'b0;
                            pat_step  = 7'd2;
                            pat_count = '0;
                        end
                    end
                    else if (pat_step == 7'd2)
                    begin
                        if (pat_count >= blink_len)
                            pat_step = 7'd0;
                    end
                end
                default:
                begin
                end
            endcase
            // only live patterns move the counter
            if (entry_cmd >= CMD_BLINK_ONCE && entry_cmd <= CMD_BLINK_FOREVER)
                pat_count = pat_count + 32'd1;
        end
        res.led_lit        = pat_lit;
        res.active_command = pat_cmd;
        res.finished       = done;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [2:0] got, logic [2:0] exp_v);
        if (error_count < PRINT_CAP)
            $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, exp_v,
                     $realtime);
        error_count++;
    endtask

    // sender: bursts of items with random gaps, prediction on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_cmd.valid   <= 1'b0;
            tick_cmd.op      <= OP_TICK;
            tick_cmd.command <= CMD_NONE;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // accepted item
            if (tick_cmd.valid && tick_cmd.ready)
            begin
                taken_item.op      = tick_cmd.op;
                taken_item.command = tick_cmd.command;
                status_due.push_back(advance_pattern(taken_item));
            end
            // next item once the current one is gone
            if (!tick_cmd.valid || tick_cmd.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    tick_cmd.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    next_item = pending_items.pop_front();
                    tick_cmd.valid   <= 1'b1;
                    tick_cmd.op      <= next_item.op;
                    tick_cmd.command <= next_item.command;
                    if (burst_left == 0)
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    tick_cmd.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus field-by-field check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status.ready <= 1'b0;
            stall_phase  <= '0;
        end
        else
        begin
            stall_phase  <= stall_phase + 4'd1;
            status.ready <= stall_pattern[stall_phase];
            if (status.valid && status.ready)
            begin
                if (status_due.size() == 0)
                begin
                    report_mismatch("unexpected status item", status.active_command, 3'd0);
                end
                else
                begin
                    want = status_due.pop_front();
                    if (status.led_lit !== want.led_lit)
                        report_mismatch("led_lit", {2'b00, status.led_lit},
                                        {2'b00, want.led_lit});
                    if (status.active_command !== want.active_command)
                        report_mismatch("active_command", status.active_command,
                                        want.active_command);
                    if (status.finished !== want.finished)
                        report_mismatch("finished", {2'b00, status.finished},
                                        {2'b00, want.finished});
                end
            end
        end
    end

    // watchdog: cycles with work outstanding but nothing accepted
    always @(posedge clk)
    begin
        if ((tick_cmd.valid && tick_cmd.ready) || (status.valid && status.ready) ||
            (pending_items.size() == 0 && status_due.size() == 0 && !tick_cmd.valid))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void push_item(logic op_v, logic [2:0] cmd_v);
        in_item_t entry;
        entry.op      = op_v;
        entry.command = cmd_v;
        pending_items.push_back(entry);
        items_queued++;
    endfunction

    function automatic void push_ticks(int count);
        for (int i = 0; i < count; i++)
            push_item(OP_TICK, CMD_NONE);
    endfunction

    // one random run: mostly pattern commands with ticks, some noise and cut-off patterns
    function automatic void queue_run();
        int         kind;
        int         span;
        int         n;
        logic [2:0] cmd;
        kind = $urandom_range(0, 99);
        span = (blink_len > 16'd40) ? 40 : int'(blink_len);
        if (kind < 60)
        begin
            cmd = 3'($urandom_range(1, 5));
            push_item(OP_WRITE, cmd);
            case (cmd)
                CMD_BLINK_ONCE:    n = span + 2 + $urandom_range(0, 3);
                CMD_BLINK_TWICE:   n = 3 * span + 4 + $urandom_range(0, 3);
                CMD_BLINK_FOREVER: n = $urandom_range(1, 4 * span + 6);
                default:           n = $urandom_range(1, 300);
            endcase
            push_ticks(n);
            // endless or long patterns get cut, then a blink once settles the phase
            if (cmd == CMD_BLINK_FOREVER || cmd == CMD_FADE_IN || cmd == CMD_FADE_OUT)
            begin
                push_item(OP_WRITE, 3'($urandom_range(0, 7)));
                push_ticks($urandom_range(0, 3));
                push_item(OP_WRITE, CMD_BLINK_ONCE);
                push_ticks(span + 3);
            end
        end
        else if (kind < 85)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                push_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        end
        else
        begin
            push_item(OP_WRITE, 3'($urandom_range(1, 5)));
            push_ticks($urandom_range(0, span + 2));
            push_item(OP_WRITE, 3'($urandom_range(0, 7)));
            push_ticks($urandom_range(1, 6));
        end
    endfunction

    // wait until every item is through, then let the pipeline settle
    task automatic drain();
        while (pending_items.size() != 0 || status_due.size() != 0 || tick_cmd.valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_phase_ticks(logic [15:0] value);
        @(posedge clk);
        phase_ticks_we    <= 1'b1;
        phase_ticks_wdata <= value;
        blink_len = value;
        @(posedge clk);
        phase_ticks_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_phase(logic [15:0] value, int budget);
        int start;
        set_phase_ticks(value);
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : (16'($urandom) | 16'h0001);
        start = items_queued;
        while (items_queued - start < budget)
            queue_run();
        drain();
    endtask

    // stimulus
    initial
    begin
        tick_cmd.valid    = 1'b0;
        tick_cmd.op       = OP_TICK;
        tick_cmd.command  = CMD_NONE;
        status.ready      = 1'b0;
        phase_ticks_we    = 1'b0;
        phase_ticks_wdata = '0;
        stall_pattern     = 16'hFFFF;
        rst_n             = 1'b0;
        blink_len         = PHASE_TICKS_RESET;
        pat_cmd           = CMD_NONE;
        pat_step          = '0;
        pat_count         = '0;
        pat_lit           = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unused codes and none at the reset blink length
        push_item(OP_TICK, CMD_NONE);
        push_item(OP_WRITE, 3'd6);
        push_item(OP_TICK, CMD_NONE);
        push_item(OP_WRITE, 3'd7);
        push_item(OP_TICK, CMD_NONE);
        push_item(OP_WRITE, CMD_NONE);
        drain();

        // each blink pattern with short phases: once and twice to their end, forever through one period
        set_phase_ticks(16'd2);
        stall_pattern = 16'hB6DB;
        push_item(OP_WRITE, CMD_BLINK_ONCE);
        push_ticks(3);
        push_item(OP_WRITE, CMD_BLINK_TWICE);
        push_ticks(7);
        push_item(OP_WRITE, CMD_BLINK_FOREVER);
        push_ticks(5);
        // blink twice left at its second phase, then a fade runs out its ramp tail
        push_item(OP_WRITE, CMD_BLINK_TWICE);
        push_ticks(3);
        push_item(OP_WRITE, CMD_FADE_IN);
        push_ticks(130);
        push_item(OP_WRITE, CMD_FADE_OUT);
        push_ticks(1);
        drain();

        // start of the fade in and fade out ramps
        stall_pattern = 16'hFFFF;
        push_item(OP_WRITE, CMD_FADE_IN);
        push_ticks(FADE_TICKS);
        push_item(OP_WRITE, CMD_FADE_OUT);
        push_ticks(FADE_TICKS);
        drain();

        // random runs over several blink lengths, extremes included
        random_phase(16'd0, 120);
        random_phase(16'd1, 120);
        random_phase(16'hFFFF, 80);
        random_phase(16'd3, 120);
        random_phase(16'($urandom_range(2, 12)), 120);
        random_phase(16'($urandom_range(5, 40)), 120);

        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
